>>> rtl/gri_pkg.sv
// Shared types, constants and elaboration-time functions for the gyro rate integrator.
// Used by every module of the block and by its checker; depends on nothing.
package gri_pkg;

  localparam int unsigned RATE_W     = 16;   // signed Q9.6 rate
  localparam int unsigned MAG_W      = 16;   // |rate|, 0..32768
  localparam int unsigned FULL_LOG2  = 15;
  localparam int unsigned FULL_SCALE = 32768;
  localparam int unsigned ANG_W      = 32;
  localparam int unsigned TAB_W      = 22;   // power table values, Q.12
  localparam int unsigned MULA_W     = 38;
  localparam int unsigned MULB_W     = 16;
  localparam int unsigned PROD_W     = MULA_W + MULB_W;
  localparam int unsigned DELTA_W    = 26;
  localparam int unsigned SUM_W      = ANG_W + 2;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned REG_ADDR_W = 5;
  localparam int unsigned IDX_LSB    = 2;
  localparam int unsigned APB_DATA_W = 32;

  // Rounding shifts for the linear and power terms, with and without the trim factor.
  localparam logic [SHIFT_W-1:0] SH_LIN   = 5'd6;
  localparam logic [SHIFT_W-1:0] SH_LIN_X = 5'd22;
  localparam logic [SHIFT_W-1:0] SH_POW   = 5'd12;
  localparam logic [SHIFT_W-1:0] SH_POW_X = 5'd28;

  localparam logic [14:0] DEADBAND_RST = 15'd45;
  localparam logic [14:0] KNEE_RST     = 15'd77;
  localparam logic [15:0] LIN_GAIN_RST = 16'd5898;
  localparam logic [15:0] POW_GAIN_RST = 16'd2708;
  localparam logic [15:0] X_TRIM_RST   = 16'd58982;

  localparam logic [63:0] Q30 = 64'd1 << 30;

  typedef enum logic [2:0] {
    REG_DEADBAND = 3'd0,
    REG_KNEE     = 3'd1,
    REG_LIN_GAIN = 3'd2,
    REG_POW_GAIN = 3'd3,
    REG_X_TRIM   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic                     clear;
  } gri_in_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle_x;
    logic signed [ANG_W-1:0] angle_y;
    logic signed [ANG_W-1:0] angle_z;
  } gri_out_t;

  typedef struct packed {
    logic [14:0] deadband;
    logic [14:0] knee;
    logic [15:0] linear_gain;
    logic [15:0] power_gain;
    logic [15:0] x_axis_trim;
  } gri_cfg_t;

  typedef struct packed {
    logic  take_in;
    logic  mag;
    logic  classify;
    logic  row1;
    logic  imul;
    logic  div_step;
    logic  interp;
    logic  gain;
    logic  trim;
    logic  round;
    logic  acc;
    logic  load_out;
    axis_t axis;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic pow;
    logic div_last;
  } dp_stat_t;

  // Floor square root, bit by bit.
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bt;
    x  = x_in;
    r  = '0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // Table value (b/64)^1.095 in Q.12, evaluated only at elaboration.
  function automatic logic [63:0] power_value(input logic [63:0] b);
    logic [63:0] roots [31];
    logic [63:0] y;
    logic [63:0] frac;
    logic [63:0] f;
    logic [63:0] q;
    logic [63:0] mant;
    longint      l;
    longint      e;
    int          n;
    if (b == 64'd0) return 64'd0;
    roots[0] = 2 * Q30;
    for (int i = 1; i <= 30; i++) roots[i] = isqrt64(roots[i-1] << 30);
    n = 63;
    while (b[n] == 1'b0) n--;
    y    = b << (30 - n);
    frac = '0;
    for (int i = 1; i <= 30; i++) begin
      y = (y * y) >> 30;
      if (y >= 2 * Q30) begin
        y    = y >> 1;
        frac = frac | (64'd1 << (30 - i));
      end
    end
    l    = longint'(n - 6) * longint'(Q30) + longint'(frac);
    e    = (l * 1095) / 1000 + 12 * longint'(Q30);
    f    = $unsigned(e) & (Q30 - 64'd1);
    q    = $unsigned(e) >> 30;
    mant = Q30;
    for (int i = 1; i <= 30; i++) begin
      if (f[30-i]) mant = (mant * roots[i] + (Q30 >> 1)) >> 30;
    end
    return ((mant << q) + (Q30 >> 1)) >> 30;
  endfunction

endpackage

>>> rtl/gri_regs.sv
// APB-style configuration registers of the gyro rate integrator.
// Depends on gri_pkg for the register indexes, reset values and the configuration struct.
module gri_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gri_pkg::REG_ADDR_W-1:0]    paddr,
  input  logic [gri_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [gri_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output gri_pkg::gri_cfg_t                 cfg
);
  import gri_pkg::*;

  gri_cfg_t cfg_r;
  gri_cfg_t cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[REG_ADDR_W-1:IDX_LSB]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_DEADBAND: cfg_nxt.deadband    = pwdata[14:0];
        REG_KNEE:     cfg_nxt.knee        = pwdata[14:0];
        REG_LIN_GAIN: cfg_nxt.linear_gain = pwdata[15:0];
        REG_POW_GAIN: cfg_nxt.power_gain  = pwdata[15:0];
        REG_X_TRIM:   cfg_nxt.x_axis_trim = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEADBAND: prdata = APB_DATA_W'(cfg_r.deadband);
      REG_KNEE:     prdata = APB_DATA_W'(cfg_r.knee);
      REG_LIN_GAIN: prdata = APB_DATA_W'(cfg_r.linear_gain);
      REG_POW_GAIN: prdata = APB_DATA_W'(cfg_r.power_gain);
      REG_X_TRIM:   prdata = APB_DATA_W'(cfg_r.x_axis_trim);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband    <= DEADBAND_RST;
      cfg_r.knee        <= KNEE_RST;
      cfg_r.linear_gain <= LIN_GAIN_RST;
      cfg_r.power_gain  <= POW_GAIN_RST;
      cfg_r.x_axis_trim <= X_TRIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/gri_ctrl.sv
// Sequencing state machine of the gyro rate integrator: walks the three axes through the datapath.
// Depends on gri_pkg for the command and status structs and the axis codes.
module gri_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gri_pkg::dp_stat_t stat,
  output gri_pkg::dp_cmd_t  cmd
);
  import gri_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_MAG    = 12'b0000_0000_0010,
    ST_CLASS  = 12'b0000_0000_0100,
    ST_ROW1   = 12'b0000_0000_1000,
    ST_IMUL   = 12'b0000_0001_0000,
    ST_DIV    = 12'b0000_0010_0000,
    ST_INTERP = 12'b0000_0100_0000,
    ST_GAIN   = 12'b0000_1000_0000,
    ST_TRIM   = 12'b0001_0000_0000,
    ST_ROUND  = 12'b0010_0000_0000,
    ST_ACC    = 12'b0100_0000_0000,
    ST_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  axis_t  axis_r, axis_nxt, axis_inc;
  logic   out_valid_r, out_valid_nxt;
  logic   last_axis;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign last_axis = (axis_r == AXIS_Z);

  always_comb begin
    unique case (axis_r)
      AXIS_X:  axis_inc = AXIS_Y;
      AXIS_Y:  axis_inc = AXIS_Z;
      default: axis_inc = AXIS_X;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.axis      = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.take_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_MAG;
          axis_nxt  = AXIS_X;
        end
      end
      ST_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        if (stat.skip) begin
          if (last_axis) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_MAG;
            axis_nxt  = axis_inc;
          end
        end else if (stat.pow) begin
          state_nxt = ST_ROW1;
        end else begin
          state_nxt = ST_GAIN;
        end
      end
      ST_ROW1: begin
        cmd.row1  = 1'b1;
        state_nxt = ST_IMUL;
      end
      ST_IMUL: begin
        cmd.imul  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_nxt  = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = (axis_r == AXIS_X) ? ST_TRIM : ST_ROUND;
      end
      ST_TRIM: begin
        cmd.trim  = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (last_axis) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MAG;
          axis_nxt  = axis_inc;
        end
      end
      ST_OUT: begin
        // The result register must be free, or be emptied in this very cycle.
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/gri_dp.sv
// Datapath of the gyro rate integrator: magnitude, power table, divider, shared multiplier,
// rounding and saturating accumulators. Depends on gri_pkg for types, widths and the table function.
module gri_dp #(
  parameter int POWER_SEGMENTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gri_pkg::gri_cfg_t cfg,
  input  gri_pkg::dp_cmd_t  cmd,
  output gri_pkg::dp_stat_t stat,
  input  gri_pkg::gri_in_t  in_item,
  output gri_pkg::gri_out_t out_item
);
  import gri_pkg::*;

  localparam int KW     = $clog2(POWER_SEGMENTS + 1);
  localparam int KP_W   = MAG_W + KW;
  localparam int SPAN_W = $clog2(FULL_SCALE / POWER_SEGMENTS + 2);
  localparam int QW     = TAB_W;
  localparam int NUM_W  = TAB_W + SPAN_W;
  localparam int CNT_W  = $clog2(QW);

  // Breakpoints and table values, fixed at elaboration.
  logic [MAG_W-1:0] rom_b [POWER_SEGMENTS+1];
  logic [TAB_W-1:0] rom_t [POWER_SEGMENTS+1];

  for (genvar g = 0; g <= POWER_SEGMENTS; g++) begin : g_rom
    localparam int unsigned BP = (g * FULL_SCALE) / POWER_SEGMENTS;
    localparam logic [63:0] PV = power_value(64'(BP));
    assign rom_b[g] = MAG_W'(BP);
    assign rom_t[g] = TAB_W'(PV);
  end

  gri_in_t                 in_r;
  logic [MAG_W-1:0]        m_r;
  logic                    neg_r;
  logic                    pow_r;
  logic [KW-1:0]           k_r;
  logic [MAG_W-1:0]        b0_r, b1_r;
  logic [TAB_W-1:0]        t0_r, t1_r;
  logic [NUM_W-1:0]        rem_r, dvs_r;
  logic [QW-1:0]           q_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [TAB_W-1:0]        p_r;
  logic [PROD_W-1:0]       mul_r;
  logic [DELTA_W-1:0]      d_r;
  logic signed [ANG_W-1:0] acc_r [3];
  gri_out_t                out_r;

  logic signed [RATE_W-1:0] rate_sel;
  logic [RATE_W-1:0]        rate_u;
  logic [MAG_W-1:0]         mag;
  logic [KP_W-1:0]          kprod;
  logic [KP_W-1:0]          kshift;
  logic [KW-1:0]            k_now;
  logic [KW-1:0]            row_idx;
  logic [MAG_W-1:0]         row_b;
  logic [TAB_W-1:0]         row_t;
  logic [SPAN_W-1:0]        span;
  logic                     ge;
  logic [MULA_W-1:0]        mul_a;
  logic [MULB_W-1:0]        mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic                     is_x;
  logic [SHIFT_W-1:0]       sh;
  logic [PROD_W:0]          rnd_sum;
  logic [PROD_W:0]          rnd_q;
  logic signed [ANG_W-1:0]  acc_cur;
  logic signed [SUM_W-1:0]  d_ext;
  logic signed [SUM_W-1:0]  sum;
  logic signed [ANG_W-1:0]  acc_sat;

  assign is_x = (cmd.axis == AXIS_X);

  always_comb begin
    case (cmd.axis)
      AXIS_X:  rate_sel = in_r.rate_x;
      AXIS_Y:  rate_sel = in_r.rate_y;
      default: rate_sel = in_r.rate_z;
    endcase
  end

  // The most negative rate maps to 32768, which still fits the unsigned magnitude.
  assign rate_u = $unsigned(rate_sel);
  assign mag    = rate_u[RATE_W-1] ? MAG_W'(~rate_u) + MAG_W'(1) : MAG_W'(rate_u);

  assign kprod   = KP_W'(m_r) * KP_W'(POWER_SEGMENTS);
  assign kshift  = kprod >> FULL_LOG2;
  assign k_now   = (kshift >= KP_W'(POWER_SEGMENTS)) ? KW'(POWER_SEGMENTS - 1) : KW'(kshift);
  assign row_idx = cmd.row1 ? k_r + KW'(1) : k_now;
  assign row_b   = rom_b[row_idx];
  assign row_t   = rom_t[row_idx];

  assign stat.skip     = (m_r <= MAG_W'(cfg.deadband));
  assign stat.pow      = (m_r > MAG_W'(cfg.knee));
  assign stat.div_last = (cnt_r == '0);

  assign span = SPAN_W'(b1_r - b0_r);
  assign ge   = (rem_r >= dvs_r);

  // One multiplier serves the interpolation product, the gain and the X trim.
  always_comb begin
    if (cmd.imul) begin
      mul_a = MULA_W'(t1_r - t0_r);
      mul_b = MULB_W'(m_r - b0_r);
    end else if (cmd.trim) begin
      mul_a = mul_r[MULA_W-1:0];
      mul_b = cfg.x_axis_trim;
    end else if (pow_r) begin
      mul_a = MULA_W'(p_r);
      mul_b = cfg.power_gain;
    end else begin
      mul_a = MULA_W'(m_r);
      mul_b = cfg.linear_gain;
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    if (pow_r) sh = is_x ? SH_POW_X : SH_POW;
    else       sh = is_x ? SH_LIN_X : SH_LIN;
    rnd_sum = {1'b0, mul_r} + ((PROD_W+1)'(1) << (sh - SHIFT_W'(1)));
    rnd_q   = rnd_sum >> sh;
  end

  always_comb begin
    case (cmd.axis)
      AXIS_X:  acc_cur = acc_r[0];
      AXIS_Y:  acc_cur = acc_r[1];
      default: acc_cur = acc_r[2];
    endcase
    d_ext = $signed({{(SUM_W-DELTA_W){1'b0}}, d_r});
    sum   = SUM_W'(acc_cur) + (neg_r ? -d_ext : d_ext);
    // Saturate when the top three bits disagree.
    if (sum[SUM_W-1:ANG_W-1] != '0 && sum[SUM_W-1:ANG_W-1] != '1) begin
      acc_sat = sum[SUM_W-1] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
    end else begin
      acc_sat = sum[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) in_r <= in_item;
    if (cmd.mag) begin
      m_r   <= mag;
      neg_r <= rate_u[RATE_W-1];
    end
    if (cmd.classify) begin
      pow_r <= stat.pow;
      k_r   <= k_now;
      b0_r  <= row_b;
      t0_r  <= row_t;
    end
    if (cmd.row1) begin
      b1_r <= row_b;
      t1_r <= row_t;
    end
    if (cmd.imul) begin
      rem_r <= NUM_W'(mul_p);
      dvs_r <= NUM_W'(span) << (QW - 1);
      q_r   <= '0;
      cnt_r <= CNT_W'(QW - 1);
    end else if (cmd.div_step) begin
      if (ge) rem_r <= rem_r - dvs_r;
      dvs_r <= dvs_r >> 1;
      q_r   <= {q_r[QW-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.interp) p_r <= t0_r + q_r;
    if (cmd.gain || cmd.trim) mul_r <= mul_p;
    if (cmd.round) d_r <= DELTA_W'(rnd_q);
    if (cmd.load_out) begin
      if (in_r.clear) begin
        out_r <= '0;
      end else begin
        out_r.angle_x <= acc_r[0];
        out_r.angle_y <= acc_r[1];
        out_r.angle_z <= acc_r[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r[0] <= '0;
      acc_r[1] <= '0;
      acc_r[2] <= '0;
    end else if (cmd.load_out && in_r.clear) begin
      acc_r[0] <= '0;
      acc_r[1] <= '0;
      acc_r[2] <= '0;
    end else if (cmd.acc) begin
      case (cmd.axis)
        AXIS_X:  acc_r[0] <= acc_sat;
        AXIS_Y:  acc_r[1] <= acc_sat;
        default: acc_r[2] <= acc_sat;
      endcase
    end
  end

  assign out_item = out_r;

endmodule

>>> rtl/gyro_rate_integrator.sv
// Top level of the three-axis gyro rate integrator.
// Depends on gri_pkg, gri_regs, gri_ctrl and gri_dp.
//
//   Channel   Direction   Handshake               Payload
//   in_       input       in_valid / in_ready     in_item   (gri_in_t)
//   out_      output      out_valid / out_ready   out_item  (gri_out_t)
//   config    input       psel, penable, pwrite   paddr, pwdata, prdata
//
// An item is taken while idle. Each axis passes the magnitude and classify states and stops
// there inside the deadband; a linear axis goes on through gain, trim (X only), round and
// accumulate, and a power-law axis first reads the upper table row, forms the interpolation
// product and runs the 22-step divider. Reset is synchronous and active low; it restores the
// register defaults and zeroes the accumulators. A stalled result waits in the output register
// while the next item is taken and worked on; only its hand-over waits for the output side.
module gyro_rate_integrator #(
  parameter int POWER_SEGMENTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gri_pkg::gri_in_t               in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gri_pkg::gri_out_t              out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gri_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [gri_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gri_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import gri_pkg::*;

  gri_cfg_t cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  gri_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gri_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gri_dp #(
    .POWER_SEGMENTS (POWER_SEGMENTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

>>> rtl/gri_checker.sv
// Port-level checks for the gyro rate integrator, attached to the top level by a bind.
// Depends on gri_pkg for the payload types and register indexes.
module gri_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input gri_pkg::gri_out_t              out_item,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [gri_pkg::REG_ADDR_W-1:0] paddr,
  input logic [gri_pkg::APB_DATA_W-1:0] pwdata,
  input logic [gri_pkg::APB_DATA_W-1:0] prdata
);
  import gri_pkg::*;

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items taken in whose results have not yet been handed over.
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) pend_nxt = pend_r + 2'd1;
    if (!in_acc && out_acc) pend_nxt = pend_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else        pend_r <= pend_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or vanished while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input ready again in the cycle after an item was taken");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result shown with no item outstanding");

  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[REG_ADDR_W-1:IDX_LSB] == REG_DEADBAND)
    |=> (paddr[REG_ADDR_W-1:IDX_LSB] != REG_DEADBAND)
        || (prdata == {17'b0, $past(pwdata[14:0])}))
    else $error("deadband register does not read back the value written");

endmodule

bind gyro_rate_integrator gri_checker u_gri_checker (.*);

>>> test/tb_gyro_rate_integrator.sv
// Self-checking testbench for the gyro rate integrator: rate items go in, angle items come out.
// A built-in predictor of the three saturating accumulators checks every result field by field.
// Depends on gri_pkg and gyro_rate_integrator.
module tb_gyro_rate_integrator;
  timeunit 1ns;
  timeprecision 1ps;

  import gri_pkg::*;

  localparam int          SEGMENTS    = 64;
  localparam longint      FULL_RANGE  = 32768;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam longint      ANGLE_MAX   = 64'sd2147483647;
  localparam longint      ANGLE_MIN   = -64'sd2147483648;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          SETTLE      = 100;

  // Register slots above the last defined register; writes there must change nothing.
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  logic clk;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_ready;
  gri_in_t  in_item  = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  gri_out_t out_item;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [REG_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  gyro_rate_integrator #(
    .POWER_SEGMENTS(SEGMENTS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predictor state: register copy, accumulators and the power-law curve.
  gri_cfg_t           shadow_regs = '{deadband: 15'd45, knee: 15'd77, linear_gain: 16'd5898,
                                      power_gain: 16'd2708, x_axis_trim: 16'd58982};
  logic signed [31:0] angle_acc [3] = '{32'sd0, 32'sd0, 32'sd0};
  logic [63:0]        root_chain [0:30];
  logic [63:0]        curve_pts [0:SEGMENTS];

  gri_in_t  rate_queue [$];
  gri_out_t expected_angles [$];

  int fail_count     = 0;
  int results_seen   = 0;
  int cycle_count    = 0;
  int settings_count = 1;
  int quiet_hits     = 0;
  int linear_hits    = 0;
  int power_hits     = 0;
  int sat_hits       = 0;
  int clear_hits     = 0;

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int bitpos = 31; bitpos >= 0; bitpos--) begin
      cand = res | (64'd1 << bitpos);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  // (b/64)^1.095 in Q.12, via a Q.30 base-2 logarithm and a product of 2^(2^-i) factors.
  function automatic logic [63:0] curve_at(input logic [63:0] b);
    logic [63:0] y;
    logic [63:0] frac;
    logic [63:0] f;
    logic [63:0] q;
    logic [63:0] mant;
    longint      lg2;
    longint      ex;
    int          n;
    if (b == 64'd0) return 64'd0;
    n = 63;
    while (b[n] == 1'b0) n--;
    y    = b << (30 - n);
    frac = '0;
    for (int i = 1; i <= 30; i++) begin
      y = (y * y) >> 30;
      if (y >= 2 * ONE_Q30) begin
        y    = y >> 1;
        frac = frac | (64'd1 << (30 - i));
      end
    end
    lg2  = longint'(n - 6) * longint'(ONE_Q30) + longint'(frac);
    ex   = (lg2 * 1095) / 1000 + 12 * longint'(ONE_Q30);
    f    = 64'(ex) & (ONE_Q30 - 64'd1);
    q    = 64'(ex) >> 30;
    mant = ONE_Q30;
    for (int i = 1; i <= 30; i++) begin
      if (f[30-i]) mant = (mant * root_chain[i] + (ONE_Q30 >> 1)) >> 30;
    end
    return ((mant << q) + (ONE_Q30 >> 1)) >> 30;
  endfunction

  function automatic logic [63:0] curve_lookup(input logic [63:0] mag);
    longint seg;
    longint b0;
    longint b1;
    longint diff;
    seg = longint'((mag * SEGMENTS) / FULL_RANGE);
    if (seg >= SEGMENTS) seg = SEGMENTS - 1;
    b0 = seg * FULL_RANGE / SEGMENTS;
    b1 = (seg + 1) * FULL_RANGE / SEGMENTS;
    if (b1 <= b0) return curve_pts[seg];
    diff = longint'(curve_pts[seg+1]) - longint'(curve_pts[seg]);
    return 64'(longint'(curve_pts[seg]) + diff * (longint'(mag) - b0) / (b1 - b0));
  endfunction

  function automatic longint axis_delta(input logic signed [15:0] rate, input bit on_x);
    logic [63:0] mag;
    logic [63:0] d;
    mag = rate[15] ? 64'(-longint'(rate)) : 64'(longint'(rate));
    if (mag <= 64'(shadow_regs.deadband)) begin
      quiet_hits++;
      return 0;
    end
    if (mag > 64'(shadow_regs.knee)) begin
      power_hits++;
      d = curve_lookup(mag) * 64'(shadow_regs.power_gain);
      if (on_x) d = (d * 64'(shadow_regs.x_axis_trim) + (64'd1 << 27)) >> 28;
      else      d = (d + (64'd1 << 11)) >> 12;
    end else begin
      linear_hits++;
      d = mag * 64'(shadow_regs.linear_gain);
      if (on_x) d = (d * 64'(shadow_regs.x_axis_trim) + (64'd1 << 21)) >> 22;
      else      d = (d + (64'd1 << 5)) >> 6;
    end
    return rate[15] ? -longint'(d) : longint'(d);
  endfunction

  function automatic gri_out_t integrate_rates(input gri_in_t s);
    logic signed [15:0] rates [3];
    longint             sum;
    gri_out_t           res;
    rates[AXIS_X] = s.rate_x;
    rates[AXIS_Y] = s.rate_y;
    rates[AXIS_Z] = s.rate_z;
    for (int a = 0; a < 3; a++) begin
      sum = longint'(angle_acc[a]) + axis_delta(rates[a], a == AXIS_X);
      if (sum > ANGLE_MAX) begin
        sum = ANGLE_MAX;
        sat_hits++;
      end else if (sum < ANGLE_MIN) begin
        sum = ANGLE_MIN;
        sat_hits++;
      end
      angle_acc[a] = sum[31:0];
    end
    if (s.clear) begin
      clear_hits++;
      for (int a = 0; a < 3; a++) angle_acc[a] = '0;
    end
    res.angle_x = angle_acc[AXIS_X];
    res.angle_y = angle_acc[AXIS_Y];
    res.angle_z = angle_acc[AXIS_Z];
    return res;
  endfunction

  function automatic void apply_reg(input logic [2:0] index, input logic [31:0] value);
    case (index)
      REG_DEADBAND: shadow_regs.deadband    = value[14:0];
      REG_KNEE:     shadow_regs.knee        = value[14:0];
      REG_LIN_GAIN: shadow_regs.linear_gain = value[15:0];
      REG_POW_GAIN: shadow_regs.power_gain  = value[15:0];
      REG_X_TRIM:   shadow_regs.x_axis_trim = value[15:0];
      default: ;
    endcase
  endfunction

  function automatic void compare_angle(input string field, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  function automatic void push_rates(input logic signed [15:0] x, input logic signed [15:0] y,
                                     input logic signed [15:0] z, input logic clr);
    gri_in_t s;
    s.rate_x = x;
    s.rate_y = y;
    s.rate_z = z;
    s.clear  = clr;
    rate_queue.push_back(s);
  endfunction

  // Rates cluster round the thresholds and the ends of the range, with plenty of plain noise.
  function automatic logic signed [15:0] pick_rate();
    logic [15:0] base;
    base = 16'($urandom);
    case ($urandom_range(0, 9))
      0: base = 16'(shadow_regs.deadband) + 16'($urandom_range(0, 2)) - 16'd1;
      1: base = 16'(shadow_regs.knee) + 16'($urandom_range(0, 2)) - 16'd1;
      2: base = 16'h7FFF - 16'($urandom_range(0, 1));
      3: base = 16'($urandom_range(0, 200));
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) base = -base;
    return base;
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      push_rates(pick_rate(), pick_rate(), pick_rate(), $urandom_range(0, 19) == 0);
  endtask

  // The sender holds off here until every expected item has come back.
  task automatic drain();
    do @(negedge clk); while (rate_queue.size() != 0 || in_valid || expected_angles.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_reg(index, value);
  endtask

  // Upper data bits carry junk, which the register widths must discard.
  task automatic load_settings(input logic [14:0] db, input logic [14:0] kn,
                               input logic [15:0] lg, input logic [15:0] pg,
                               input logic [15:0] tr);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_DEADBAND, {junk[31:15], db});
    write_reg(REG_KNEE,     {junk[16:0], kn});
    write_reg(REG_LIN_GAIN, {junk[31:16], lg});
    write_reg(REG_POW_GAIN, {junk[15:0], pg});
    write_reg(REG_X_TRIM,   {junk[23:8], tr});
    settings_count++;
  endtask

  // Sender: bursts of random length separated by random gaps, some of them long.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (rate_queue.size() != 0) begin
        in_item  <= rate_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) == 0)      gap_left = 0;
          else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(13, 100);
          else                                gap_left = $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a 16-bit ready pattern, played out bit by bit and redrawn each time it runs out.
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_pos   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_pat[pat_pos];
      if (pat_pos == 15) begin
        pat_pos = 0;
        case ($urandom_range(0, 2))
          0:       ready_pat = 16'hFFFF;
          1:       ready_pat = 16'($urandom) | 16'h0001;
          default: ready_pat = (16'($urandom) & 16'($urandom)) | 16'h0100;
        endcase
      end else begin
        pat_pos++;
      end
    end
  end

  always @(posedge clk) begin
    gri_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          $error("angle item delivered with no rate item waiting for it");
          fail_count++;
        end else begin
          want = expected_angles.pop_front();
          compare_angle("angle_x", want.angle_x, out_item.angle_x);
          compare_angle("angle_y", want.angle_y, out_item.angle_y);
          compare_angle("angle_z", want.angle_z, out_item.angle_z);
          results_seen++;
        end
      end
      if (in_valid && in_ready) expected_angles.push_back(integrate_rates(in_item));
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out with %0d items queued and %0d results outstanding",
             rate_queue.size(), expected_angles.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    root_chain[0] = 2 * ONE_Q30;
    for (int i = 1; i <= 30; i++) root_chain[i] = floor_root(root_chain[i-1] << 30);
    for (int k = 0; k <= SEGMENTS; k++) curve_pts[k] = curve_at(64'(k * FULL_RANGE / SEGMENTS));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: thresholds, boundaries either side, table breakpoints and the range ends.
    push_rates(0, 0, 0, 1'b0);
    push_rates(45, -45, 44, 1'b0);
    push_rates(46, -46, 77, 1'b0);
    push_rates(78, -78, -77, 1'b0);
    push_rates(32767, -32768, -32767, 1'b0);
    push_rates(-32768, 32767, 1, 1'b0);
    push_rates(100, 1000, 10000, 1'b0);
    push_rates(512, 511, 513, 1'b0);
    push_rates(-1, -2, 32256, 1'b0);
    push_rates(16'h5555, 16'hAAAA, 16'h2AAA, 1'b0);
    push_rates(5000, -5000, 20000, 1'b1);
    push_rates(0, 0, 0, 1'b1);
    push_rates(-20000, 12345, -32768, 1'b0);
    queue_random(200);
    drain();

    // Every gain at full scale with both thresholds at zero: drive all axes into saturation.
    load_settings(15'd0, 15'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_rates(1, -1, 0, 1'b0);
    for (int i = 0; i < 80; i++)
      push_rates(16'(32000 + $urandom_range(0, 767)), 32767, 32767, 1'b0);
    for (int i = 0; i < 80; i++)
      push_rates(-32768, -16'(32000 + $urandom_range(0, 767)), -32768, 1'b0);
    queue_random(100);
    drain();

    // Knee below the deadband; the spare register slots are written too.
    load_settings(15'd200, 15'd100, 16'd1000, 16'd30000, 16'd1);
    for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++) write_reg(3'(r), $urandom);
    push_rates(150, -201, 200, 1'b0);
    push_rates(-150, 201, -200, 1'b0);
    queue_random(100);
    drain();

    // Thresholds at their maximum: only the most negative rate gets through.
    load_settings(15'h7FFF, 15'h7FFF, 16'($urandom), 16'($urandom), 16'($urandom));
    push_rates(-32768, 32767, -32767, 1'b0);
    queue_random(80);
    drain();

    load_settings(15'd0, 15'd16384, 16'd0, 16'd0, 16'd0);
    queue_random(80);
    drain();

    // Linear path over nearly the whole range at full gain.
    load_settings(15'd0, 15'h7FFF, 16'hFFFF, 16'($urandom), 16'hFFFF);
    queue_random(100);
    drain();

    for (int p = 0; p < 2; p++) begin
      load_settings(15'($urandom_range(0, 3000)), 15'($urandom_range(0, 32767)),
                    16'($urandom), 16'($urandom), 16'($urandom));
      queue_random(100);
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (expected_angles.size() != 0) begin
      $error("%0d angle items never arrived", expected_angles.size());
      fail_count++;
    end

    $display("Checked %0d angle items over %0d register settings in %0d cycles.",
             results_seen, settings_count, cycle_count);
    $display("Axis updates: %0d in deadband, %0d linear, %0d power law; %0d clamps, %0d clears.",
             quiet_hits, linear_hits, power_hits, sat_hits, clear_hits);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
